>>> hw/rtl/odo_pkg.sv
// Shared constants, types and the arctangent table for the differential drive odometry block.
package odo_pkg;

	localparam int unsigned POSITION_BITS_DEF = 48;
	localparam int unsigned TRIG_STEPS_DEF    = 24;

	localparam int CFG_INDEX_BITS = 4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_DIST_PER_TICK = 4'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_TURN_GAIN     = 4'd1;

	localparam logic [31:0] DIST_PER_TICK_RESET = 32'd5262285;
	localparam logic [31:0] TURN_GAIN_RESET     = 32'd2065151925;

	// CORDIC start vector: 2^30 divided by the CORDIC gain
	localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

	localparam logic [13:0] RATE_SCALE = 14'd15625;
	localparam logic [31:0] RATE_POS_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] RATE_NEG_MAX = 32'h8000_0000;

	localparam logic [31:0] ATAN_TAB [32] = '{
		32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
		32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
		32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001,
		32'h00000000, 32'h00000000
	};

	typedef enum logic [3:0] {
		MUL_NONE,
		MUL_MEAN,
		MUL_DMAG,
		MUL_THI,
		MUL_TLO,
		MUL_XLO,
		MUL_XHI,
		MUL_YLO,
		MUL_YHI
	} mul_op_t;

	typedef struct packed {
		logic    take;
		logic    load;
		mul_op_t mul;
		logic    trig_start;
		logic    apply_x;
		logic    apply_y;
		logic    div_start;
		logic    div_sel;
		logic    take_lin;
		logic    take_ang;
		logic    out_load;
	} odo_cmd_t;

	typedef struct packed {
		logic trig_busy;
		logic div_busy;
		logic dt_zero;
	} odo_sts_t;

endpackage

>>> hw/rtl/odo_cordic.sv
// Iterative CORDIC unit giving sine and cosine of a binary angle as sign and magnitude.
module odo_cordic #(
	parameter int unsigned TRIG_STEPS = odo_pkg::TRIG_STEPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] angle,
	output logic        busy,
	output logic [31:0] cos_mag,
	output logic        cos_neg,
	output logic [31:0] sin_mag,
	output logic        sin_neg
);
	import odo_pkg::*;

	localparam int CW = $clog2(TRIG_STEPS);

	logic signed [33:0] x_q, y_q, z_q;
	logic signed [33:0] xs, ys, at;
	logic signed [33:0] x_abs, y_abs;
	logic [CW-1:0]      cnt_q;
	logic               busy_q, flip_q;
	logic               flip;
	logic [31:0]        r;

	// fold the left half plane onto the right one
	always_comb begin
		flip = angle[31] ^ angle[30];
		r    = flip ? angle - 32'h8000_0000 : angle;
		xs   = x_q >>> cnt_q;
		ys   = y_q >>> cnt_q;
		at   = signed'({2'b00, ATAN_TAB[5'(cnt_q)]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == CW'(TRIG_STEPS - 1)) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= CORDIC_X0;
			y_q    <= '0;
			z_q    <= signed'({{2{r[31]}}, r});
			flip_q <= flip;
		end else if (busy_q) begin
			if (!z_q[33]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	always_comb begin
		x_abs   = x_q[33] ? -x_q : x_q;
		y_abs   = y_q[33] ? -y_q : y_q;
		cos_mag = x_abs[31:0];
		sin_mag = y_abs[31:0];
		cos_neg = (x_q != '0) && (x_q[33] ^ flip_q);
		sin_neg = (y_q != '0) && (y_q[33] ^ flip_q);
	end

	assign busy = busy_q;

endmodule

>>> hw/rtl/odo_div.sv
// Restoring divider for the rate outputs: scaled magnitude over time delta, one bit a cycle.
module odo_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] mag,
	input  logic        neg,
	input  logic [31:0] dt,
	output logic        busy,
	output logic [31:0] rate
);
	import odo_pkg::*;

	logic [77:0] rem_q;
	logic [72:0] dsh_q;
	logic [31:0] quo_q;
	logic [4:0]  cnt_q;
	logic        busy_q, neg_q;
	logic        ge;
	logic [77:0] dsh_ext;

	always_comb begin
		dsh_ext = {5'b0, dsh_q};
		ge      = rem_q >= dsh_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == 5'd31) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// divisor starts at dt * 2^10 * 2^31; a set top quotient bit means saturation
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= 78'(mag) * 78'(RATE_SCALE);
			dsh_q <= {dt, 41'b0};
			quo_q <= '0;
			neg_q <= neg;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dsh_ext;
			end
			quo_q <= {quo_q[30:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end

	always_comb begin
		if (neg_q) begin
			rate = quo_q[31] ? RATE_NEG_MAX : 32'(-quo_q);
		end else begin
			rate = quo_q[31] ? RATE_POS_MAX : quo_q;
		end
	end

	assign busy = busy_q;

endmodule

>>> hw/rtl/odo_dp.sv
// Odometry datapath: configuration, sample state, shared multiplier, pose and result registers.
module odo_dp #(
	parameter int unsigned POSITION_BITS = odo_pkg::POSITION_BITS_DEF,
	parameter int unsigned TRIG_STEPS    = odo_pkg::TRIG_STEPS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [odo_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [31:0]                         cfg_data,
	input  logic signed [31:0]                  left_count,
	input  logic signed [31:0]                  right_count,
	input  logic [31:0]                         stamp_us,
	input  odo_pkg::odo_cmd_t                   cmd,
	output odo_pkg::odo_sts_t                   sts,
	output logic signed [POSITION_BITS-1:0]     pos_x,
	output logic signed [POSITION_BITS-1:0]     pos_y,
	output logic [31:0]                         heading,
	output logic signed [31:0]                  linear_rate,
	output logic signed [31:0]                  angular_rate,
	output logic                                rate_invalid
);
	import odo_pkg::*;

	localparam logic signed [65:0] POS_HI = (66'sd1 <<< (POSITION_BITS - 1)) - 66'sd1;
	localparam logic signed [65:0] POS_LO = -POS_HI - 66'sd1;

	logic [31:0] dpt_q, tg_q;
	logic [31:0] prev_left_q, prev_right_q, prev_stamp_q;
	logic [31:0] angle_q;
	logic signed [POSITION_BITS-1:0] acc_x_q, acc_y_q;

	logic [31:0] qmag_q, ddmag_q, dt_q;
	logic        qneg_q, odd_q, ddneg_q;

	logic signed [31:0] dl, dr;
	logic signed [32:0] s, dd, dd_abs;
	logic signed [31:0] q;

	logic [31:0] mul_a, mul_b;
	logic [63:0] prod_q;
	mul_op_t     op_q;

	logic [63:0] mm_q, dmag_q, thi_q, turn_q, lo_q, mm_d;
	logic        mneg_q;
	logic signed [63:0] step_x_q, step_y_q, step_val;
	logic [65:0] st_sum;
	logic [62:0] st_mag;
	logic        st_neg;

	logic [31:0] cmag_q, smag_q, cmag, smag;
	logic        cneg_q, sneg_q, cneg, sneg;
	logic        trig_busy, div_busy;
	logic [31:0] div_rate;
	logic signed [31:0] lin_q, ang_q;
	logic signed [65:0] sum_x, sum_y;
	logic signed [POSITION_BITS-1:0] new_x, new_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dpt_q <= DIST_PER_TICK_RESET;
			tg_q  <= TURN_GAIN_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_DIST_PER_TICK) begin
				dpt_q <= cfg_data;
			end
			if (cfg_index == REG_TURN_GAIN) begin
				tg_q <= cfg_data;
			end
		end
	end

	// wrapped tick deltas, floor half sum and wheel difference
	always_comb begin
		dl     = signed'(left_count - prev_left_q);
		dr     = signed'(right_count - prev_right_q);
		s      = 33'(dl) + 33'(dr);
		q      = 32'(s >>> 1);
		dd     = 33'(dr) - 33'(dl);
		dd_abs = dd[32] ? -dd : dd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_left_q  <= '0;
			prev_right_q <= '0;
			prev_stamp_q <= '0;
		end else if (cmd.take) begin
			prev_left_q  <= left_count;
			prev_right_q <= right_count;
			prev_stamp_q <= stamp_us;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			qneg_q  <= q[31];
			qmag_q  <= q[31] ? 32'(-q) : q;
			odd_q   <= s[0];
			ddneg_q <= dd[32];
			ddmag_q <= dd_abs[31:0];
			dt_q    <= stamp_us - prev_stamp_q;
		end
	end

	odo_cordic #(
		.TRIG_STEPS(TRIG_STEPS)
	) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.trig_start),
		.angle   (angle_q),
		.busy    (trig_busy),
		.cos_mag (cmag),
		.cos_neg (cneg),
		.sin_mag (smag),
		.sin_neg (sneg)
	);

	always_ff @(posedge clk) begin
		cmag_q <= cmag;
		cneg_q <= cneg;
		smag_q <= smag;
		sneg_q <= sneg;
	end

	always_comb begin
		unique case (cmd.mul)
			MUL_MEAN: begin mul_a = qmag_q;         mul_b = dpt_q;  end
			MUL_DMAG: begin mul_a = ddmag_q;        mul_b = dpt_q;  end
			MUL_THI:  begin mul_a = dmag_q[63:32];  mul_b = tg_q;   end
			MUL_TLO:  begin mul_a = dmag_q[31:0];   mul_b = tg_q;   end
			MUL_XLO:  begin mul_a = mm_q[31:0];     mul_b = cmag_q; end
			MUL_XHI:  begin mul_a = mm_q[63:32];    mul_b = cmag_q; end
			MUL_YLO:  begin mul_a = mm_q[31:0];     mul_b = smag_q; end
			MUL_YHI:  begin mul_a = mm_q[63:32];    mul_b = smag_q; end
			default:  begin mul_a = '0;             mul_b = '0;     end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= MUL_NONE;
		end else begin
			op_q <= cmd.mul;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= {32'b0, mul_a} * {32'b0, mul_b};
	end

	// mean travel magnitude: add or take off half a tick for an odd sum
	always_comb begin
		if (!odd_q) begin
			mm_d = prod_q;
		end else if (qneg_q) begin
			mm_d = prod_q - {33'b0, dpt_q[31:1]};
		end else begin
			mm_d = prod_q + {33'b0, dpt_q[31:1]};
		end
	end

	// floor(|m| * |trig| / 2^30), capped, then signed
	always_comb begin
		st_sum   = {prod_q, 2'b00} + {32'b0, lo_q[63:30]};
		st_mag   = (st_sum[65:63] != 3'b000) ? {63{1'b1}} : st_sum[62:0];
		st_neg   = mneg_q ^ ((op_q == MUL_XHI) ? cneg_q : sneg_q);
		step_val = st_neg ? -signed'({1'b0, st_mag}) : signed'({1'b0, st_mag});
	end

	always_ff @(posedge clk) begin
		unique case (op_q)
			MUL_MEAN: begin
				mm_q   <= mm_d;
				mneg_q <= qneg_q && (mm_d != '0);
			end
			MUL_DMAG: dmag_q   <= prod_q;
			MUL_THI:  thi_q    <= prod_q;
			MUL_TLO:  turn_q   <= thi_q + {32'b0, prod_q[63:32]};
			MUL_XLO:  lo_q     <= prod_q;
			MUL_YLO:  lo_q     <= prod_q;
			MUL_XHI:  step_x_q <= step_val;
			MUL_YHI:  step_y_q <= step_val;
			default: ;
		endcase
	end

	// saturating position update
	always_comb begin
		sum_x = 66'(acc_x_q) + 66'(step_x_q);
		sum_y = 66'(acc_y_q) + 66'(step_y_q);
		if (sum_x > POS_HI) begin
			new_x = POS_HI[POSITION_BITS-1:0];
		end else if (sum_x < POS_LO) begin
			new_x = POS_LO[POSITION_BITS-1:0];
		end else begin
			new_x = sum_x[POSITION_BITS-1:0];
		end
		if (sum_y > POS_HI) begin
			new_y = POS_HI[POSITION_BITS-1:0];
		end else if (sum_y < POS_LO) begin
			new_y = POS_LO[POSITION_BITS-1:0];
		end else begin
			new_y = sum_y[POSITION_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_x_q <= '0;
			acc_y_q <= '0;
			angle_q <= '0;
		end else begin
			if (cmd.apply_x) begin
				acc_x_q <= new_x;
			end
			if (cmd.apply_y) begin
				acc_y_q <= new_y;
				angle_q <= ddneg_q ? angle_q - turn_q[31:0] : angle_q + turn_q[31:0];
			end
		end
	end

	odo_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.mag    (cmd.div_sel ? turn_q : mm_q),
		.neg    (cmd.div_sel ? ddneg_q : mneg_q),
		.dt     (dt_q),
		.busy   (div_busy),
		.rate   (div_rate)
	);

	always_ff @(posedge clk) begin
		if (cmd.take_lin) begin
			lin_q <= signed'(div_rate);
		end
		if (cmd.take_ang) begin
			ang_q <= signed'(div_rate);
		end
		if (cmd.out_load) begin
			pos_x        <= acc_x_q;
			pos_y        <= acc_y_q;
			heading      <= angle_q;
			linear_rate  <= sts.dt_zero ? '0 : lin_q;
			angular_rate <= sts.dt_zero ? '0 : ang_q;
			rate_invalid <= sts.dt_zero;
		end
	end

	always_comb begin
		sts.trig_busy = trig_busy;
		sts.div_busy  = div_busy;
		sts.dt_zero   = (dt_q == '0);
	end

endmodule

>>> hw/rtl/odo_ctrl.sv
// Odometry controller: sequences multiplies, CORDIC, rate divisions and the result transaction.
module odo_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  odo_pkg::odo_sts_t sts,
	output odo_pkg::odo_cmd_t cmd
);
	import odo_pkg::*;

	typedef enum logic [17:0] {
		ST_IDLE  = 18'h00001,
		ST_MEAN  = 18'h00002,
		ST_DMAG  = 18'h00004,
		ST_BUB   = 18'h00008,
		ST_THI   = 18'h00010,
		ST_TLO   = 18'h00020,
		ST_WTRIG = 18'h00040,
		ST_XLO   = 18'h00080,
		ST_XHI   = 18'h00100,
		ST_YLO   = 18'h00200,
		ST_YHI   = 18'h00400,
		ST_APX   = 18'h00800,
		ST_APY   = 18'h01000,
		ST_DLS   = 18'h02000,
		ST_DLW   = 18'h04000,
		ST_DAS   = 18'h08000,
		ST_DAW   = 18'h10000,
		ST_OUT   = 18'h20000
	} state_t;

	state_t state_q, state_d;
	logic   primed_q, out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.mul = MUL_NONE;
		unique case (state_q)
			ST_IDLE: begin
				cmd.take = in_valid;
				cmd.load = in_valid && primed_q;
				if (in_valid && primed_q) begin
					state_d = ST_MEAN;
				end
			end
			ST_MEAN: begin
				cmd.mul        = MUL_MEAN;
				cmd.trig_start = 1'b1;
				state_d        = ST_DMAG;
			end
			ST_DMAG: begin
				cmd.mul = MUL_DMAG;
				state_d = ST_BUB;
			end
			ST_BUB: state_d = ST_THI;
			ST_THI: begin
				cmd.mul = MUL_THI;
				state_d = ST_TLO;
			end
			ST_TLO: begin
				cmd.mul = MUL_TLO;
				state_d = ST_WTRIG;
			end
			ST_WTRIG: begin
				if (!sts.trig_busy) begin
					state_d = ST_XLO;
				end
			end
			ST_XLO: begin
				cmd.mul = MUL_XLO;
				state_d = ST_XHI;
			end
			ST_XHI: begin
				cmd.mul = MUL_XHI;
				state_d = ST_YLO;
			end
			ST_YLO: begin
				cmd.mul = MUL_YLO;
				state_d = ST_YHI;
			end
			ST_YHI: begin
				cmd.mul = MUL_YHI;
				state_d = ST_APX;
			end
			ST_APX: begin
				cmd.apply_x = 1'b1;
				state_d     = ST_APY;
			end
			ST_APY: begin
				cmd.apply_y = 1'b1;
				state_d     = sts.dt_zero ? ST_OUT : ST_DLS;
			end
			ST_DLS: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DLW;
			end
			ST_DLW: begin
				if (!sts.div_busy) begin
					cmd.take_lin = 1'b1;
					state_d      = ST_DAS;
				end
			end
			ST_DAS: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = 1'b1;
				state_d       = ST_DAW;
			end
			ST_DAW: begin
				cmd.div_sel = 1'b1;
				if (!sts.div_busy) begin
					cmd.take_ang = 1'b1;
					state_d      = ST_OUT;
				end
			end
			ST_OUT: begin
				// hold until the output register is free
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			primed_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.take) begin
				primed_q <= 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

>>> hw/rtl/differential_drive_odometry.sv
// Differential drive wheel odometry: top level joining controller and datapath.
// Each transaction on the input carries accumulated left and right encoder counts and a
// microsecond stamp. The first one after reset only records them and gives no result.
// Every later one advances x and y by the mean wheel travel along the old heading, turns
// the heading, and yields one result transaction with the pose and the linear and angular
// rates (zero, flagged by rate_invalid, when the stamp did not move). Samples are handled
// one at a time: after a primed sample is accepted, the next one is accepted only once its
// result has been loaded into the output register, which waits for that register to be
// free; an unprimed sample leaves the block idle. The time taken is set by the iterative
// CORDIC for sine and cosine and by the one-bit-per-cycle divider, which runs once for each
// of the two rates; both divisions are skipped when the time delta is zero. A finished
// result waits in the output register while the next sample is taken in. Configuration
// writes are always ready and should be made while the block is idle.
module differential_drive_odometry #(
	parameter int unsigned POSITION_BITS = odo_pkg::POSITION_BITS_DEF,
	parameter int unsigned TRIG_STEPS    = odo_pkg::TRIG_STEPS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [odo_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [31:0]                        cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [31:0]                 left_count,
	input  logic signed [31:0]                 right_count,
	input  logic [31:0]                        stamp_us,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [POSITION_BITS-1:0]    pos_x,
	output logic signed [POSITION_BITS-1:0]    pos_y,
	output logic [31:0]                        heading,
	output logic signed [31:0]                 linear_rate,
	output logic signed [31:0]                 angular_rate,
	output logic                               rate_invalid
);
	import odo_pkg::*;

	odo_cmd_t cmd;
	odo_sts_t sts;

	assign cfg_ready = 1'b1;

	odo_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	odo_dp #(
		.POSITION_BITS (POSITION_BITS),
		.TRIG_STEPS    (TRIG_STEPS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.left_count   (left_count),
		.right_count  (right_count),
		.stamp_us     (stamp_us),
		.cmd          (cmd),
		.sts          (sts),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.heading      (heading),
		.linear_rate  (linear_rate),
		.angular_rate (angular_rate),
		.rate_invalid (rate_invalid)
	);

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid || !out_stall))
		else $error("result loaded over a stalled result");

	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.out_load))
		else $error("result valid without a load");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && rate_invalid) |-> (linear_rate == '0 && angular_rate == '0))
		else $error("rates not zero with rate_invalid");

	a_trig_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.trig_start |-> (!sts.trig_busy && !sts.div_busy))
		else $error("CORDIC started while a unit is busy");

endmodule
